>>> src/skt_pkg.sv
package skt_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		ACT_INSERT   = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_CONTAINS = 3'd2,
		ACT_NEXT     = 3'd3,
		ACT_SEE_AT   = 3'd4,
		ACT_REWIND   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// per-cycle command broadcast along the chain
	typedef struct packed {
		logic capture;
		logic ins_wr;
		logic rm_wr;
	} cell_ctrl_t;

endpackage

>>> src/skt_cell.sv
module skt_cell (
	input  logic                             clk,
	input  skt_pkg::cell_ctrl_t              ctrl,
	input  logic [skt_pkg::KEY_WIDTH-1:0]    key,
	input  logic                             occupied,
	input  logic [skt_pkg::KEY_WIDTH-1:0]    left_key,
	input  logic                             left_lt,
	input  logic [skt_pkg::KEY_WIDTH-1:0]    right_key,
	output logic [skt_pkg::KEY_WIDTH-1:0]    entry,
	output logic                             lt,
	output logic                             eq
);

	logic [skt_pkg::KEY_WIDTH-1:0] entry_q;
	logic                          lt_s1;
	logic                          eq_s1;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			lt_s1 <= occupied && (entry_q < key);
			eq_s1 <= occupied && (entry_q == key);
		end
	end

	// cells left of the insert point keep their key; the insert point takes
	// the new key, cells to its right take their left neighbour's key
	always_ff @(posedge clk) begin
		if (ctrl.ins_wr && !lt_s1) begin
			entry_q <= left_lt ? key : left_key;
		end else if (ctrl.rm_wr && !lt_s1) begin
			entry_q <= right_key;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_s1;
	assign eq    = eq_s1;

endmodule

>>> src/sorted_key_table.sv
// sorted_key_table: sorted key store built as a chain of compare-and-shift cells.
// Each cell registers its compare when a request is accepted; the shift or read and the result
// write follow in S_EXEC, which holds while an untaken result remains; in_ready is low meanwhile.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous): count and cursor cleared, no result pending;
// entry contents are not cleared.
module sorted_key_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] key,
	input  logic [3:0]  index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] key_out,
	output logic [4:0]  entry_count,
	output logic        is_empty
);

	localparam int CAP = skt_pkg::CAPACITY;
	localparam int KW  = skt_pkg::KEY_WIDTH;
	localparam int CW  = skt_pkg::CNT_W;
	localparam int IW  = skt_pkg::IDX_W;

	skt_pkg::state_t    state_q, state_d;
	skt_pkg::cell_ctrl_t ctrl;

	logic [2:0]    action_s1;
	logic [KW-1:0] key_s1;
	logic [3:0]    index_s1;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] cursor_q, cursor_d;

	logic          out_valid_q;
	logic [1:0]    status_q, status_d;
	logic [31:0]   key_out_q, key_out_d;
	logic [CW-1:0] res_count_d;

	logic [KW-1:0] bus_key;
	logic [KW-1:0] entry_vec [CAP];
	logic [CAP-1:0] lt_vec, eq_vec;
	logic          found;
	logic          fire;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] nxt_idx;
	logic          ins_wr, rm_wr;

	// ---------------- cell chain ----------------
	assign bus_key = (state_q == skt_pkg::S_IDLE) ? KW'(key) : key_s1;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [KW-1:0] lk, rk;
		logic          llt;
		if (i == 0) begin : g_first
			assign lk  = entry_vec[0];
			assign llt = 1'b1;
		end else begin : g_mid
			assign lk  = entry_vec[i-1];
			assign llt = lt_vec[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign rk = entry_vec[i];
		end else begin : g_inner
			assign rk = entry_vec[i+1];
		end
		skt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (bus_key),
			.occupied  (CW'(i) < count_q),
			.left_key  (lk),
			.left_lt   (llt),
			.right_key (rk),
			.entry     (entry_vec[i]),
			.lt        (lt_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	assign found = |eq_vec;
	assign fire  = (state_q == skt_pkg::S_EXEC) && (!out_valid_q || out_ready);

	// ---------------- control ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			skt_pkg::S_IDLE: if (in_valid) state_d = skt_pkg::S_EXEC;
			skt_pkg::S_EXEC: if (fire) state_d = skt_pkg::S_IDLE;
			default:         state_d = skt_pkg::S_IDLE;
		endcase
	end

	assign in_ready = (state_q == skt_pkg::S_IDLE);

	// cursor at or past the end wraps to the front before the read
	assign rd_idx  = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;
	assign nxt_idx = (32'(rd_idx) + 32'd1 >= 32'(CAP)) ? '0 : IW'(32'(rd_idx) + 32'd1);

	always_comb begin
		status_d  = skt_pkg::ST_OK;
		key_out_d = '0;
		count_d   = count_q;
		cursor_d  = cursor_q;
		ins_wr    = 1'b0;
		rm_wr     = 1'b0;
		case (action_s1)
			skt_pkg::ACT_INSERT: begin
				if (32'(count_q) >= 32'(CAP)) begin
					status_d = skt_pkg::ST_FULL;
				end else begin
					ins_wr  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			skt_pkg::ACT_REMOVE: begin
				if (found) begin
					rm_wr     = 1'b1;
					key_out_d = 32'(key_s1);
					count_d   = count_q - CW'(1);
				end else begin
					status_d = skt_pkg::ST_NOT_FOUND;
				end
			end
			skt_pkg::ACT_CONTAINS: begin
				if (!found) status_d = skt_pkg::ST_NOT_FOUND;
			end
			skt_pkg::ACT_NEXT: begin
				if (count_q == '0) begin
					status_d = skt_pkg::ST_RANGE;
				end else begin
					key_out_d = 32'(entry_vec[rd_idx]);
					cursor_d  = nxt_idx;
				end
			end
			skt_pkg::ACT_SEE_AT: begin
				if (32'(index_s1) >= 32'(count_q)) begin
					status_d = skt_pkg::ST_RANGE;
				end else begin
					key_out_d = 32'(entry_vec[IW'(index_s1)]);
				end
			end
			skt_pkg::ACT_REWIND: cursor_d = '0;
			default: ;
		endcase
		res_count_d = count_d;
	end

	always_comb begin
		ctrl.capture = (state_q == skt_pkg::S_IDLE) && in_valid;
		ctrl.ins_wr  = fire && ins_wr;
		ctrl.rm_wr   = fire && rm_wr;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skt_pkg::S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				count_q     <= count_d;
				cursor_q    <= cursor_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			action_s1 <= action;
			key_s1    <= KW'(key);
			index_s1  <= index;
		end
		if (fire) begin
			status_q  <= status_d;
			key_out_q <= key_out_d;
		end
	end

	logic [CW-1:0] res_count_q;
	always_ff @(posedge clk) begin
		if (fire) res_count_q <= res_count_d;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign key_out     = key_out_q;
	assign entry_count = 5'(res_count_q);
	assign is_empty    = (res_count_q == '0);

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(CAP))
		else $error("entry count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_wr |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rm_wr |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not shrink the count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skt_pkg::S_EXEC) && out_valid_q && !out_ready |=>
			(state_q == skt_pkg::S_EXEC) && $stable(count_q))
		else $error("request retired while result still pending");

endmodule
